### sv/rwc_pkg.sv
// Shared constants, types and register codes for the RGB window convolution block.
// Used by every module of the block; depends on nothing.
package rwc_pkg;
   localparam int MaxWidth     = 4096;
   localparam int MaxHeight    = 4096;
   localparam int MaxKernel    = 5;
   localparam int Channels     = 3;
   localparam int CoefFracBits = 8;
   localparam int DimW         = 13;
   localparam int ColW         = $clog2(MaxWidth);
   localparam int CountW       = 26;
   localparam int PixW         = 24;
   localparam int LbW          = (MaxKernel - 1) * PixW;
   localparam int NumCoef      = MaxKernel * MaxKernel;
   localparam int CoefIdxW     = $clog2(NumCoef);
   localparam int NumBanks     = 6;
   localparam int OutW         = 20;
   localparam int OutMax       = (1 << OutW) - 1;
   localparam int ProdW        = 24;
   localparam int RowSumW      = ProdW + 3;
   localparam int SumW         = RowSumW + 3;
   localparam int QueueDepth   = 4;
   localparam int QueuePtrW    = $clog2(QueueDepth);
   localparam int QueueCntW    = QueuePtrW + 1;
   localparam int GeomW        = 33;
   localparam logic [GeomW-1:0] GeomReset = 33'd1812463680;

   typedef enum logic [2:0] {
      CSR_COEF0, CSR_COEF1, CSR_COEF2, CSR_COEF3,
      CSR_COEF4, CSR_COEF5, CSR_COEF6, CSR_GEOM
   } csr_index_type;

   typedef logic [PixW-1:0] pix_type;
   typedef pix_type [MaxKernel-1:0][MaxKernel-1:0] win_type;
   typedef logic signed [15:0] coef_type;
   typedef coef_type [MaxKernel-1:0][MaxKernel-1:0] coef_win_type;

   typedef struct packed {
      logic [DimW-1:0]   width;
      logic [DimW-1:0]   height;
      logic [2:0]        kw;
      logic [2:0]        kh;
      logic              pad;
      logic [2:0]        lr;
      logic [2:0]        lc;
      logic [CountW-1:0] lat;
      logic [CountW-1:0] total;
   } geom_type;

   typedef struct packed {
      logic hold;
      logic restart;
   } front_ctrl_type;

   typedef struct packed {
      win_type win;
      logic    last;
   } qent_type;
endpackage

### sv/rwc_req_if.sv
// Input pixel channel: valid/ready handshake with kind and RGB samples.
// Standalone; no package dependency.
interface rwc_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

### sv/rwc_rsp_if.sv
// Result channel: valid/ready handshake with three 20-bit magnitudes and frame end.
// Standalone; no package dependency.
interface rwc_rsp_if;
   logic        valid;
   logic        ready;
   logic [19:0] red_out;
   logic [19:0] green_out;
   logic [19:0] blue_out;
   logic        frame_end;
   modport source (output valid, red_out, green_out, blue_out, frame_end, input ready);
   modport sink (input valid, red_out, green_out, blue_out, frame_end, output ready);
endinterface

### sv/rwc_csr_if.sv
// Register write channel: valid/ready handshake with index and 64-bit data.
// Standalone; no package dependency.
interface rwc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [63:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### sv/rwc_front.sv
// Front end: raster counters, window classification, line buffer and window taps.
// Depends on rwc_pkg and rwc_req_if; pushes masked windows into the queue.
module rwc_front (
   input  logic                            clock,
   input  logic                            reset,
   input  rwc_pkg::geom_type               geom,
   input  rwc_pkg::front_ctrl_type         ctrl,
   input  logic [rwc_pkg::QueueCntW-1:0]   q_level,
   rwc_req_if.sink                         req_if,
   output logic                            push_valid,
   output rwc_pkg::qent_type               push_data
);
   import rwc_pkg::*;

   logic                 acc;
   logic [ColW-1:0]      col_ff, col_in, ocol_ff, ocol_in;
   logic [DimW-1:0]      row_ff, row_in, orow_ff, orow_in;
   logic [CountW-1:0]    pos_ff, pos_in;
   logic                 emit, last, wrap;
   logic [DimW:0]        rr, cc;
   logic [MaxKernel-1:0] row_ok, col_ok;
   pix_type              sample;

   logic                 p1_valid_ff, p1_emit_ff, p1_last_ff;
   logic [ColW-1:0]      p1_col_ff;
   pix_type              p1_sample_ff;
   logic [MaxKernel-1:0] p1_row_ok_ff, p1_col_ok_ff;

   logic [LbW-1:0]       lb_mem [MaxWidth];
   logic [LbW-1:0]       lb_rd_ff, byp_data_ff, lb_data, wr_data;
   logic                 byp_hit_ff;
   pix_type [MaxKernel-1:0] col_vec;
   win_type              win_ff, win_in;
   logic                 pend;

   assign acc  = req_if.valid && req_if.ready;
   assign pend = p1_valid_ff && p1_emit_ff;
   assign req_if.ready = !ctrl.hold &&
      ((QueueCntW + 1)'(q_level) + (QueueCntW + 1)'(pend) < (QueueCntW + 1)'(QueueDepth));
   assign sample = req_if.kind ? '0 : {req_if.blue_in, req_if.green_in, req_if.red_in};

   always_comb begin
      rr   = '0;
      cc   = '0;
      emit = 1'b0;
      last = 1'b0;
      wrap = 1'b0;
      if (geom.pad) begin
         rr   = (DimW + 1)'(orow_ff) + (DimW + 1)'(geom.lr);
         cc   = (DimW + 1)'(ocol_ff) + (DimW + 1)'(geom.lc);
         emit = (pos_ff >= geom.lat) && (orow_ff < geom.height);
         last = (orow_ff == geom.height - 1'b1) &&
                (DimW'(ocol_ff) == geom.width - 1'b1);
         wrap = emit && last;
      end else begin
         rr   = (DimW + 1)'(row_ff);
         cc   = (DimW + 1)'(col_ff);
         emit = (DimW'(geom.kw) <= geom.width) && (DimW'(geom.kh) <= geom.height) &&
                (row_ff >= DimW'(geom.kh) - 1'b1) &&
                (DimW'(col_ff) >= DimW'(geom.kw) - 1'b1) && (row_ff < geom.height);
         last = (pos_ff == geom.total - 1'b1);
         wrap = (pos_ff >= geom.total - 1'b1);
      end
      for (int k = 0; k < MaxKernel; k++) begin
         row_ok[k] = (3'(k) < geom.kh) && (rr >= (DimW + 1)'(k)) &&
                     (rr - (DimW + 1)'(k) < (DimW + 1)'(geom.height));
         col_ok[k] = (3'(k) < geom.kw) && (cc >= (DimW + 1)'(k)) &&
                     (cc - (DimW + 1)'(k) < (DimW + 1)'(geom.width));
      end
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      ocol_in = ocol_ff;
      orow_in = orow_ff;
      pos_in  = pos_ff;
      if (ctrl.restart) begin
         col_in  = '0;
         row_in  = '0;
         ocol_in = '0;
         orow_in = '0;
         pos_in  = '0;
      end else if (acc) begin
         pos_in = pos_ff + 1'b1;
         if (DimW'(col_ff) + 1'b1 >= geom.width) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
         if (emit && geom.pad) begin
            if (DimW'(ocol_ff) + 1'b1 >= geom.width) begin
               ocol_in = '0;
               orow_in = orow_ff + 1'b1;
            end else begin
               ocol_in = ocol_ff + 1'b1;
            end
         end
         if (wrap) begin
            col_in  = '0;
            row_in  = '0;
            ocol_in = '0;
            orow_in = '0;
            pos_in  = '0;
         end
      end
   end

   // column vector of the item in stage 1: its own sample, then rows above
   always_comb begin
      lb_data    = byp_hit_ff ? byp_data_ff : lb_rd_ff;
      col_vec[0] = p1_sample_ff;
      for (int k = 1; k < MaxKernel; k++) begin
         col_vec[k] = lb_data[(k - 1) * PixW +: PixW];
      end
      for (int k = 0; k < MaxKernel - 1; k++) begin
         wr_data[k * PixW +: PixW] = col_vec[k];
      end
      for (int j = 0; j < MaxKernel; j++) begin
         win_in[j][0] = col_vec[j];
         for (int d = 1; d < MaxKernel; d++) begin
            win_in[j][d] = win_ff[j][d - 1];
         end
      end
      push_data.last = p1_last_ff;
      for (int j = 0; j < MaxKernel; j++) begin
         for (int d = 0; d < MaxKernel; d++) begin
            push_data.win[j][d] = (p1_row_ok_ff[j] && p1_col_ok_ff[d]) ? win_in[j][d] : '0;
         end
      end
   end

   assign push_valid = pend;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         ocol_ff     <= '0;
         orow_ff     <= '0;
         pos_ff      <= '0;
         p1_valid_ff <= 1'b0;
         byp_hit_ff  <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         ocol_ff     <= ocol_in;
         orow_ff     <= orow_in;
         pos_ff      <= pos_in;
         p1_valid_ff <= acc;
         byp_hit_ff  <= acc && p1_valid_ff && (p1_col_ff == col_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         p1_emit_ff   <= emit;
         p1_last_ff   <= last;
         p1_col_ff    <= col_ff;
         p1_sample_ff <= sample;
         p1_row_ok_ff <= row_ok;
         p1_col_ok_ff <= col_ok;
         lb_rd_ff     <= lb_mem[col_ff];
         byp_data_ff  <= wr_data;
      end
      if (p1_valid_ff) begin
         lb_mem[p1_col_ff] <= wr_data;
         win_ff            <= win_in;
      end
   end
endmodule

### sv/rwc_fifo.sv
// Short queue of masked windows between front end and arithmetic back end.
// Depends on rwc_pkg.
module rwc_fifo (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  rwc_pkg::qent_type               push_data,
   input  logic                            pop,
   output rwc_pkg::qent_type               head,
   output logic                            empty,
   output logic [rwc_pkg::QueueCntW-1:0]   level
);
   import rwc_pkg::*;

   qent_type               mem_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QueueCntW-1:0]   level_ff;

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = (level_ff == '0);
   assign level = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         level_ff <= level_ff + QueueCntW'(push) - QueueCntW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

### sv/rwc_back.sv
// Back end: per-tap products, row sums, total, magnitude and saturation, output register.
// Depends on rwc_pkg and rwc_rsp_if; pops windows from the queue.
module rwc_back (
   input  logic                    clock,
   input  logic                    reset,
   input  rwc_pkg::coef_win_type   tap_coef,
   input  rwc_pkg::qent_type       head,
   input  logic                    empty,
   output logic                    pop,
   rwc_rsp_if.source               rsp_if
);
   import rwc_pkg::*;

   logic                      en;
   logic                      a_valid_ff, a_last_ff, b_valid_ff, b_last_ff;
   logic                      out_valid_ff, out_last_ff;
   logic signed [ProdW-1:0]   prod_in [Channels][MaxKernel][MaxKernel];
   logic signed [ProdW-1:0]   prod_ff [Channels][MaxKernel][MaxKernel];
   logic signed [RowSumW-1:0] rsum_in [Channels][MaxKernel];
   logic signed [RowSumW-1:0] rsum_ff [Channels][MaxKernel];
   logic signed [24:0]        full [Channels][MaxKernel][MaxKernel];
   logic signed [SumW-1:0]    tot [Channels];
   logic [SumW-1:0]           mag [Channels];
   logic [SumW-1:0]           shv [Channels];
   logic [OutW-1:0]           res_in [Channels];
   logic [OutW-1:0]           res_ff [Channels];

   assign en  = !out_valid_ff || rsp_if.ready;
   assign pop = en && !empty;

   always_comb begin
      for (int c = 0; c < Channels; c++) begin
         for (int j = 0; j < MaxKernel; j++) begin
            for (int d = 0; d < MaxKernel; d++) begin
               full[c][j][d]    = $signed({1'b0, head.win[j][d][8 * c +: 8]}) * tap_coef[j][d];
               prod_in[c][j][d] = full[c][j][d][ProdW-1:0];
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < Channels; c++) begin
         for (int j = 0; j < MaxKernel; j++) begin
            rsum_in[c][j] = '0;
            for (int d = 0; d < MaxKernel; d++) begin
               rsum_in[c][j] = rsum_in[c][j] + RowSumW'(prod_ff[c][j][d]);
            end
         end
      end
   end

   always_comb begin
      for (int c = 0; c < Channels; c++) begin
         tot[c] = '0;
         for (int j = 0; j < MaxKernel; j++) begin
            tot[c] = tot[c] + SumW'(rsum_ff[c][j]);
         end
         mag[c]    = tot[c][SumW-1] ? SumW'(-tot[c]) : SumW'(tot[c]);
         shv[c]    = mag[c] >> CoefFracBits;
         res_in[c] = (shv[c] > SumW'(OutMax)) ? OutW'(OutMax) : shv[c][OutW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff   <= !empty;
         b_valid_ff   <= a_valid_ff;
         out_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff     <= prod_in;
         a_last_ff   <= head.last;
         rsum_ff     <= rsum_in;
         b_last_ff   <= a_last_ff;
         res_ff      <= res_in;
         out_last_ff <= b_last_ff;
      end
   end

   assign rsp_if.valid     = out_valid_ff;
   assign rsp_if.red_out   = res_ff[0];
   assign rsp_if.green_out = res_ff[1];
   assign rsp_if.blue_out  = res_ff[2];
   assign rsp_if.frame_end = out_last_ff;
endmodule

### sv/rgb_window_convolution_abs_core.sv
// In same-size mode a result also waits for the border rows and columns to arrive.
// Throughput: one beat per cycle while the queue has room and no register write
// holds the input, set by one line buffer read and one line buffer write per beat.
// Reset: counters, queue and valids clear; coefficients zero; 64x64 3x3 valid mode;
// the input holds off for one cycle after reset and after each register write.
// The line buffer is not cleared. Depends on rwc_pkg, the interfaces and submodules.
module rgb_window_convolution_abs_core (
   input  logic      clock,
   input  logic      reset,
   rwc_req_if.sink   req_if,
   rwc_rsp_if.source rsp_if,
   rwc_csr_if.sink   csr_if
);
   import rwc_pkg::*;

   logic [63:0]          coef_bank_ff [NumBanks];
   logic [15:0]          coef6_ff;
   logic [GeomW-1:0]     geom_raw_ff;
   logic                 hold_ff;
   logic                 csr_acc;
   geom_type             geom_ff, geom_in;
   coef_type             coef_all [NumCoef];
   coef_win_type         tap_coef_ff, tap_coef_in;
   front_ctrl_type       ctrl;
   logic                 q_push, q_pop, q_empty;
   qent_type             q_push_data, q_head;
   logic [QueueCntW-1:0] q_level;
   logic [DimW-1:0]      w_raw, h_raw;
   logic [2:0]           kw_raw, kh_raw;

   assign csr_if.ready = 1'b1;
   assign csr_acc      = csr_if.valid && csr_if.ready;
   assign ctrl.hold    = hold_ff;
   assign ctrl.restart = csr_acc && (csr_index_type'(csr_if.index) == CSR_GEOM);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NumBanks; n++) begin
            coef_bank_ff[n] <= '0;
         end
         coef6_ff    <= '0;
         geom_raw_ff <= GeomReset;
         hold_ff     <= 1'b1;
      end else begin
         hold_ff <= csr_acc;
         if (csr_acc) begin
            unique case (csr_index_type'(csr_if.index))
               CSR_COEF0, CSR_COEF1, CSR_COEF2, CSR_COEF3, CSR_COEF4, CSR_COEF5: begin
                  coef_bank_ff[csr_if.index] <= csr_if.data;
               end
               CSR_COEF6: begin
                  coef6_ff <= csr_if.data[15:0];
               end
               CSR_GEOM: begin
                  geom_raw_ff <= csr_if.data[GeomW-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      w_raw  = geom_raw_ff[12:0];
      h_raw  = geom_raw_ff[25:13];
      kw_raw = geom_raw_ff[28:26];
      kh_raw = geom_raw_ff[31:29];
      geom_in.width  = (w_raw == '0) ? DimW'(1) :
                       (w_raw > DimW'(MaxWidth)) ? DimW'(MaxWidth) : w_raw;
      geom_in.height = (h_raw == '0) ? DimW'(1) :
                       (h_raw > DimW'(MaxHeight)) ? DimW'(MaxHeight) : h_raw;
      geom_in.kw     = (kw_raw == '0) ? 3'd1 : (kw_raw > 3'(MaxKernel)) ? 3'(MaxKernel) : kw_raw;
      geom_in.kh     = (kh_raw == '0) ? 3'd1 : (kh_raw > 3'(MaxKernel)) ? 3'(MaxKernel) : kh_raw;
      geom_in.pad    = geom_raw_ff[32];
      geom_in.lr     = (geom_in.kh - 1'b1) - ((geom_in.kh - 1'b1) >> 1);
      geom_in.lc     = (geom_in.kw - 1'b1) - ((geom_in.kw - 1'b1) >> 1);
      geom_in.lat    = CountW'(geom_in.lr) * CountW'(geom_in.width) + CountW'(geom_in.lc);
      geom_in.total  = CountW'(geom_in.width) * CountW'(geom_in.height);
   end

   always_comb begin
      for (int n = 0; n < NumCoef; n++) begin
         if (n / 4 < NumBanks) begin
            coef_all[n] = coef_bank_ff[n / 4][16 * (n % 4) +: 16];
         end else begin
            coef_all[n] = coef6_ff;
         end
      end
      for (int j = 0; j < MaxKernel; j++) begin
         for (int d = 0; d < MaxKernel; d++) begin
            if ((3'(j) < geom_ff.kh) && (3'(d) < geom_ff.kw)) begin
               tap_coef_in[j][d] = coef_all[CoefIdxW'((int'(geom_ff.kh) - 1 - j) *
                                   int'(geom_ff.kw) + (int'(geom_ff.kw) - 1 - d))];
            end else begin
               tap_coef_in[j][d] = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      geom_ff     <= geom_in;
      tap_coef_ff <= tap_coef_in;
   end

   rwc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .geom       (geom_ff),
      .ctrl       (ctrl),
      .q_level    (q_level),
      .req_if     (req_if),
      .push_valid (q_push),
      .push_data  (q_push_data)
   );

   rwc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .head      (q_head),
      .empty     (q_empty),
      .level     (q_level)
   );

   rwc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .tap_coef (tap_coef_ff),
      .head     (q_head),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp_if   (rsp_if)
   );

`ifndef NO_ASSERTIONS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (q_push && (q_level == QueueCntW'(QueueDepth))) |-> q_pop)
      else $error("window queue overflow");

   a_hold_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_acc |=> !req_if.ready)
      else $error("input taken right after a register write");

   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (q_level != '0))
      else $error("pop from empty window queue");
`endif
endmodule
